>>> hdl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// shared widths, payload structs and small arithmetic helpers for the
// point-in-triangle pipeline
// ----------------------------------------------------------------------------
package pit_pkg;

    // coordinate width, signed q8.8
    localparam int COORD_W  = 16;
    // edge vector component width
    localparam int DIFF_W   = COORD_W + 1;
    // one component product
    localparam int PROD_W   = 2 * DIFF_W;
    // sum of three products
    localparam int DOT_W    = PROD_W + 2;
    // split of a dot product for the wide multiplier
    localparam int LO_W     = DOT_W / 2;
    localparam int HI_W     = DOT_W - LO_W;
    localparam int HH_W     = 2 * HI_W;
    localparam int HL_W     = HI_W + LO_W + 1;
    localparam int LL_W     = 2 * LO_W;
    // product of two dot products
    localparam int WPROD_W  = 2 * DOT_W;
    // determinant and numerators
    localparam int NUM_W    = WPROD_W + 1;
    // den - (un + vn)
    localparam int CMP_W    = NUM_W + 2;
    // register stages from input to output register
    localparam int NSTAGE   = 7;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_a_z;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_b_z;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
        logic signed [COORD_W-1:0] vert_c_z;
    } t_pit_in;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_pit_out;

    typedef struct packed {
        logic signed [DOT_W-1:0] d00;
        logic signed [DOT_W-1:0] d01;
        logic signed [DOT_W-1:0] d02;
        logic signed [DOT_W-1:0] d11;
        logic signed [DOT_W-1:0] d12;
    } t_pit_dots;

    typedef struct packed {
        logic signed [WPROD_W-1:0] d00_d11;
        logic signed [WPROD_W-1:0] d01_d01;
        logic signed [WPROD_W-1:0] d11_d02;
        logic signed [WPROD_W-1:0] d01_d12;
        logic signed [WPROD_W-1:0] d00_d12;
        logic signed [WPROD_W-1:0] d01_d02;
    } t_pit_wprods;

    function automatic logic signed [PROD_W-1:0] mul_diff(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic signed [DOT_W-1:0] dot_sum(
        input logic signed [PROD_W-1:0] p0,
        input logic signed [PROD_W-1:0] p1,
        input logic signed [PROD_W-1:0] p2
    );
        return DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
    endfunction

endpackage

>>> hdl/point_in_triangle_test.sv
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined datapath
// stall: the whole pipeline holds while the output register is full and not taken
// reset: synchronous active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
// point_in_triangle_test
// barycentric point-in-triangle test on signed q8.8 coordinates, one
// transaction in and one result out per test, no division
// ----------------------------------------------------------------------------
module point_in_triangle_test
    import pit_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // input channel
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_pit_in  i_in_data,
    // output channel
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pit_out o_out_data
);

    // pipeline stages
    //   1  edge vectors v0 = c - a, v1 = b - a, v2 = p - a
    //   2  component products
    //   3  five dot products d00 d01 d02 d11 d12
    //   4  half-width partial products of the six wide products
    //   5  wide products assembled
    //   6  den, un and vn
    //   7  flags, output register

    logic              stage_en;
    logic [NSTAGE-1:0] n_vld, r_vld;
    t_pit_dots         dots;
    t_pit_wprods       wp;

    // every stage moves together; a full output register that is not
    // being drained freezes the pipe, bubbles included
    assign stage_en   = !(r_vld[NSTAGE-1] && !i_out_ready);
    assign o_in_ready = stage_en;

    // valid bits ride alongside the data
    always_comb begin
        n_vld = {r_vld[NSTAGE-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (stage_en) begin
            r_vld <= n_vld;
        end
    end

    // stages 1 to 3: edge vectors and dot products
    pit_diff_dot u_diff_dot (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_data (i_in_data),
        .o_dots (dots)
    );

    // stages 4 and 5: the six wide products of dot products
    pit_wide_mul u_mul_d00_d11 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (dots.d00),
        .i_b   (dots.d11),
        .o_p   (wp.d00_d11)
    );

    pit_wide_mul u_mul_d01_d01 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (dots.d01),
        .i_b   (dots.d01),
        .o_p   (wp.d01_d01)
    );

    pit_wide_mul u_mul_d11_d02 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (dots.d11),
        .i_b   (dots.d02),
        .o_p   (wp.d11_d02)
    );

    pit_wide_mul u_mul_d01_d12 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (dots.d01),
        .i_b   (dots.d12),
        .o_p   (wp.d01_d12)
    );

    pit_wide_mul u_mul_d00_d12 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (dots.d00),
        .i_b   (dots.d12),
        .o_p   (wp.d00_d12)
    );

    pit_wide_mul u_mul_d01_d02 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_a   (dots.d01),
        .i_b   (dots.d02),
        .o_p   (wp.d01_d02)
    );

    // stages 6 and 7: determinant, numerators, inside and degenerate flags
    // a zero determinant marks a degenerate triangle and forces inside low
    pit_decide u_decide (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_wp  (wp),
        .o_res (o_out_data)
    );

    assign o_out_valid = r_vld[NSTAGE-1];

endmodule

>>> hdl/pit_diff_dot.sv
// ----------------------------------------------------------------------------
// pit_diff_dot
// edge vectors from vertex a, component products and the five dot products,
// three register stages
// ----------------------------------------------------------------------------
module pit_diff_dot
    import pit_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_pit_in   i_data,
    output t_pit_dots o_dots
);

    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] va [3];
    logic signed [COORD_W-1:0] vb [3];
    logic signed [COORD_W-1:0] vc [3];

    logic signed [DIFF_W-1:0] n_v0 [3], r_v0 [3];
    logic signed [DIFF_W-1:0] n_v1 [3], r_v1 [3];
    logic signed [DIFF_W-1:0] n_v2 [3], r_v2 [3];

    logic signed [PROD_W-1:0] n_p00 [3], r_p00 [3];
    logic signed [PROD_W-1:0] n_p01 [3], r_p01 [3];
    logic signed [PROD_W-1:0] n_p02 [3], r_p02 [3];
    logic signed [PROD_W-1:0] n_p11 [3], r_p11 [3];
    logic signed [PROD_W-1:0] n_p12 [3], r_p12 [3];

    t_pit_dots n_dots, r_dots;

    always_comb begin
        pt[0] = i_data.point_x;
        pt[1] = i_data.point_y;
        pt[2] = i_data.point_z;
        va[0] = i_data.vert_a_x;
        va[1] = i_data.vert_a_y;
        va[2] = i_data.vert_a_z;
        vb[0] = i_data.vert_b_x;
        vb[1] = i_data.vert_b_y;
        vb[2] = i_data.vert_b_z;
        vc[0] = i_data.vert_c_x;
        vc[1] = i_data.vert_c_y;
        vc[2] = i_data.vert_c_z;
        for (int k = 0; k < 3; k++) begin
            // v0 = c - a, v1 = b - a, v2 = p - a
            n_v0[k] = DIFF_W'(vc[k]) - DIFF_W'(va[k]);
            n_v1[k] = DIFF_W'(vb[k]) - DIFF_W'(va[k]);
            n_v2[k] = DIFF_W'(pt[k]) - DIFF_W'(va[k]);
            n_p00[k] = mul_diff(r_v0[k], r_v0[k]);
            n_p01[k] = mul_diff(r_v0[k], r_v1[k]);
            n_p02[k] = mul_diff(r_v0[k], r_v2[k]);
            n_p11[k] = mul_diff(r_v1[k], r_v1[k]);
            n_p12[k] = mul_diff(r_v1[k], r_v2[k]);
        end
        n_dots.d00 = dot_sum(r_p00[0], r_p00[1], r_p00[2]);
        n_dots.d01 = dot_sum(r_p01[0], r_p01[1], r_p01[2]);
        n_dots.d02 = dot_sum(r_p02[0], r_p02[1], r_p02[2]);
        n_dots.d11 = dot_sum(r_p11[0], r_p11[1], r_p11[2]);
        n_dots.d12 = dot_sum(r_p12[0], r_p12[1], r_p12[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0   <= n_v0;
            r_v1   <= n_v1;
            r_v2   <= n_v2;
            r_p00  <= n_p00;
            r_p01  <= n_p01;
            r_p02  <= n_p02;
            r_p11  <= n_p11;
            r_p12  <= n_p12;
            r_dots <= n_dots;
        end
    end

    assign o_dots = r_dots;

endmodule

>>> hdl/pit_wide_mul.sv
// ----------------------------------------------------------------------------
// pit_wide_mul
// signed product of two dot products, split into four half-width partial
// products, two register stages
// ----------------------------------------------------------------------------
module pit_wide_mul
    import pit_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [DOT_W-1:0]   i_a,
    input  logic signed [DOT_W-1:0]   i_b,
    output logic signed [WPROD_W-1:0] o_p
);

    logic signed [HI_W-1:0]    a_hi, b_hi;
    logic        [LO_W-1:0]    a_lo, b_lo;
    logic signed [HH_W-1:0]    n_hh, r_hh;
    logic signed [HL_W-1:0]    n_hl, r_hl;
    logic signed [HL_W-1:0]    n_lh, r_lh;
    logic        [LL_W-1:0]    n_ll, r_ll;
    logic signed [WPROD_W-1:0] n_p, r_p;

    always_comb begin
        a_hi = i_a[DOT_W-1:LO_W];
        b_hi = i_b[DOT_W-1:LO_W];
        a_lo = i_a[LO_W-1:0];
        b_lo = i_b[LO_W-1:0];
        // high parts signed, low parts unsigned
        n_hh = HH_W'(a_hi) * HH_W'(b_hi);
        n_hl = HL_W'(a_hi) * HL_W'($signed({1'b0, b_lo}));
        n_lh = HL_W'(b_hi) * HL_W'($signed({1'b0, a_lo}));
        n_ll = LL_W'(a_lo) * LL_W'(b_lo);
        n_p  = (WPROD_W'(r_hh) <<< (2 * LO_W))
             + ((WPROD_W'(r_hl) + WPROD_W'(r_lh)) <<< LO_W)
             + $signed(WPROD_W'(r_ll));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

>>> hdl/pit_decide.sv
// ----------------------------------------------------------------------------
// pit_decide
// determinant and barycentric numerators, then the inside and degenerate
// flags, two register stages
// ----------------------------------------------------------------------------
module pit_decide
    import pit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_pit_wprods i_wp,
    output t_pit_out    o_res
);

    logic signed [NUM_W-1:0] n_den, r_den;
    logic signed [NUM_W-1:0] n_un, r_un;
    logic signed [NUM_W-1:0] n_vn, r_vn;
    logic signed [CMP_W-1:0] slack;
    t_pit_out                n_res, r_res;

    always_comb begin
        n_den = NUM_W'(i_wp.d00_d11) - NUM_W'(i_wp.d01_d01);
        n_un  = NUM_W'(i_wp.d11_d02) - NUM_W'(i_wp.d01_d12);
        n_vn  = NUM_W'(i_wp.d00_d12) - NUM_W'(i_wp.d01_d02);
        slack = CMP_W'(r_den) - CMP_W'(r_un) - CMP_W'(r_vn);
        n_res.degenerate = (r_den == '0);
        n_res.inside_res = (r_den != '0) && !r_un[NUM_W-1] && !r_vn[NUM_W-1]
                           && !slack[CMP_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= n_den;
            r_un  <= n_un;
            r_vn  <= n_vn;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
